@@ src/ssi_pkg.sv @@
// Shared definitions for the sampled series interpolator.
// Holds defaults, register indexes, queue entry and sequencer state types.
// No dependencies.
package ssi_pkg;

   localparam int DEF_TABLE_DEPTH   = 4096;
   localparam int DEF_FRACTION_BITS = 16;
   localparam int QUEUE_DEPTH       = 2;

   localparam int DATA_WIDTH      = 32;
   localparam int INDEX_WIDTH     = 12;
   localparam int COUNT_WIDTH     = 13;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_FACTOR      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_TIME_STEP = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_COUNT      = 2'd2;

   localparam logic [DATA_WIDTH-1:0] SCALE_FACTOR_RESET      = 32'h0001_0000;
   localparam logic [DATA_WIDTH-1:0] INVERSE_TIME_STEP_RESET = 32'h0001_0000;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_QUERY,
      KIND_EMPTY
   } ssi_kind_type;

   typedef struct packed {
      ssi_kind_type           kind;
      logic [INDEX_WIDTH-1:0] index;
      logic [DATA_WIDTH-1:0]  operand;
   } ssi_entry_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] scale_factor;
      logic [DATA_WIDTH-1:0]        inverse_time_step;
   } ssi_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_LOC,
      ST_PEAK,
      ST_DIFF,
      ST_INTERP,
      ST_SUM,
      ST_GAIN,
      ST_OUT
   } ssi_state_type;

endpackage

@@ src/ssi_front.sv @@
// Front end: accepts request transactions and classifies them for the queue.
// Drops loads outside the table, marks queries that cannot hit the table.
// Depends on ssi_pkg.
module ssi_front #(
   parameter int TABLE_DEPTH = ssi_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [ssi_pkg::INDEX_WIDTH-1:0]       req_sample_index,
   input  logic signed [ssi_pkg::DATA_WIDTH-1:0] req_sample_value,
   input  logic signed [ssi_pkg::DATA_WIDTH-1:0] req_query_time,
   input  logic                                  count_zero,
   input  logic                                  q_full,
   output logic                                  q_push,
   output ssi_pkg::ssi_entry_type                q_entry
);
   import ssi_pkg::*;

   logic index_ok;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign index_ok  = 32'(req_sample_index) < 32'(TABLE_DEPTH);

   always_comb begin
      q_entry.index = req_sample_index;
      if (req_type == REQ_LOAD) begin
         q_entry.kind    = KIND_LOAD;
         q_entry.operand = req_sample_value;
      end else begin
         q_entry.kind    = (req_query_time < 0 || count_zero) ? KIND_EMPTY : KIND_QUERY;
         q_entry.operand = req_query_time;
      end
   end

   assign q_push = accept && (req_type == REQ_QUERY || index_ok);

endmodule

@@ src/ssi_queue.sv @@
// Short queue between the front end and the back end.
// Holds classified transactions so either side can stall independently.
// Depends on ssi_pkg.
module ssi_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ssi_pkg::ssi_entry_type push_entry,
   output logic                   full,
   output logic                   pop_valid,
   output ssi_pkg::ssi_entry_type pop_entry,
   input  logic                   pop
);
   import ssi_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   ssi_entry_type entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/ssi_back.sv @@
// Back end: sample memory, peak tracker, shared multiplier sequencer, result register.
// Executes loads in the idle state and queries as a sequence of steps, cut short when out of range.
// Depends on ssi_pkg.
module ssi_back #(
   parameter int TABLE_DEPTH   = ssi_pkg::DEF_TABLE_DEPTH,
   parameter int FRACTION_BITS = ssi_pkg::DEF_FRACTION_BITS,
   parameter int CNT_W         = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  ssi_pkg::ssi_entry_type                q_entry,
   output logic                                  q_pop,
   input  ssi_pkg::ssi_cfg_type                  cfg,
   input  logic [CNT_W-1:0]                      count_eff,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ssi_pkg::DATA_WIDTH-1:0] rsp_factor_value,
   output logic signed [ssi_pkg::DATA_WIDTH-1:0] rsp_peak_value,
   output logic                                  rsp_in_range
);
   import ssi_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int F  = FRACTION_BITS;

   function automatic logic [31:0] gain_sat(input logic signed [65:0] p);
      logic signed [65:0] s;
      s = p >>> F;
      if (s > 66'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (s < -66'sd2147483648) begin
         return 32'h8000_0000;
      end
      return s[31:0];
   endfunction

   ssi_state_type state_ff, state_in;

   logic signed [31:0] mem [TABLE_DEPTH];
   logic signed [31:0] rd_ff;
   logic [AW-1:0]      mem_addr;
   logic               mem_we;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_ff, mul_in;
   logic               mul_en;

   logic [30:0]        peak_ff;
   logic signed [32:0] abs_val;
   logic [30:0]        mag;

   logic signed [31:0] time_ff;
   logic               empty_ff;
   logic [AW-1:0]      idx_ff;
   logic [F-1:0]       frac_ff;
   logic               ok_ff;
   logic [31:0]        peak_res_ff;
   logic signed [31:0] v1_ff;
   logic signed [32:0] diff_ff;
   logic signed [31:0] val_ff;
   logic signed [65:0] shifted;

   logic [65-2*F:0]    idx_raw;
   logic [63:0]        idx_full;
   logic               range_ok;

   logic               out_free, out_load;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_factor_ff, rsp_peak_ff;
   logic               rsp_in_range_ff;

   assign idx_raw  = mul_ff[65:2*F];
   assign idx_full = 64'(idx_raw);
   assign range_ok = (idx_full + 64'd1) < 64'(count_eff);
   assign mul_in   = mul_a * mul_b;
   assign shifted  = mul_ff >>> F;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign abs_val = (q_entry.operand[31]) ? -33'(signed'(q_entry.operand))
                                          : 33'(signed'(q_entry.operand));
   assign mag     = (abs_val > 33'sd2147483647) ? 31'h7FFF_FFFF : abs_val[30:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_entry.kind != KIND_LOAD) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD:   state_in = ST_LOC;
         ST_LOC:    state_in = ST_PEAK;
         ST_PEAK:   state_in = ok_ff ? ST_DIFF : ST_OUT;
         ST_DIFF:   state_in = ST_INTERP;
         ST_INTERP: state_in = ST_SUM;
         ST_SUM:    state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_addr = idx_ff;
      mul_en   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop    = q_valid;
            mem_we   = q_valid && q_entry.kind == KIND_LOAD;
            mem_addr = AW'(32'(q_entry.index));
         end
         ST_PROD: begin
            mul_en = 1'b1;
            mul_a  = 33'(time_ff);
            mul_b  = signed'(33'(cfg.inverse_time_step));
         end
         ST_LOC: begin
            mem_addr = idx_full[AW-1:0];
            mul_en   = 1'b1;
            mul_a    = signed'(33'(peak_ff));
            mul_b    = 33'(cfg.scale_factor);
         end
         ST_PEAK: begin
            mem_addr = idx_ff + 1'b1;
         end
         ST_INTERP: begin
            mul_en = 1'b1;
            mul_a  = diff_ff;
            mul_b  = signed'(33'(frac_ff));
         end
         ST_GAIN: begin
            mul_en = 1'b1;
            mul_a  = 33'(val_ff);
            mul_b  = 33'(cfg.scale_factor);
         end
         ST_OUT: begin
            out_load = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= signed'(q_entry.operand);
      end
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         mul_ff <= mul_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (mem_we && mag > peak_ff) begin
         peak_ff <= mag;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            time_ff  <= signed'(q_entry.operand);
            empty_ff <= q_entry.kind == KIND_EMPTY;
         end
         ST_LOC: begin
            idx_ff  <= idx_full[AW-1:0];
            frac_ff <= mul_ff[2*F-1:F];
            ok_ff   <= !empty_ff && range_ok;
         end
         ST_PEAK: begin
            peak_res_ff <= gain_sat(mul_ff);
            v1_ff       <= rd_ff;
         end
         ST_DIFF: begin
            diff_ff <= 33'(rd_ff) - 33'(v1_ff);
         end
         ST_SUM: begin
            val_ff <= v1_ff + signed'(shifted[31:0]);
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_factor_ff   <= ok_ff ? gain_sat(mul_ff) : '0;
         rsp_peak_ff     <= peak_res_ff;
         rsp_in_range_ff <= ok_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_factor_value = signed'(rsp_factor_ff);
   assign rsp_peak_value   = signed'(rsp_peak_ff);
   assign rsp_in_range     = rsp_in_range_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_zero_when_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_in_range_ff) |-> (rsp_factor_ff == '0))
      else $error("out-of-range result carries a non-zero value");

   a_interp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> ok_ff)
      else $error("interpolation started for an out-of-range query");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (peak_ff >= $past(peak_ff)))
      else $error("peak magnitude decreased");

endmodule

@@ src/sampled_series_interpolator.sv @@
// Linear interpolation over a table of equally spaced signed Q16.16 samples. A load
// transaction is done by the back end in its idle state and gives no result; a query
// goes from the peak step straight to output when its time falls outside the loaded
// samples. The back end has a single shared 33x33 multiplier (four products per in-range
// query) and a single-port sample memory (two reads per query). A two-entry queue lets
// requests be taken while the back end works and while a result waits in the output
// register. The sample memory is not cleared at reset; only written entries may be queried.
module sampled_series_interpolator #(
   parameter int TABLE_DEPTH   = ssi_pkg::DEF_TABLE_DEPTH,
   parameter int FRACTION_BITS = ssi_pkg::DEF_FRACTION_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_type,
   input  logic [ssi_pkg::INDEX_WIDTH-1:0]           req_sample_index,
   input  logic signed [ssi_pkg::DATA_WIDTH-1:0]     req_sample_value,
   input  logic signed [ssi_pkg::DATA_WIDTH-1:0]     req_query_time,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [ssi_pkg::DATA_WIDTH-1:0]     rsp_factor_value,
   output logic signed [ssi_pkg::DATA_WIDTH-1:0]     rsp_peak_value,
   output logic                                      rsp_in_range,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ssi_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [ssi_pkg::DATA_WIDTH-1:0]            csr_data
);
   import ssi_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   ssi_cfg_type            cfg_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [CNT_W-1:0]       count_eff;
   logic                   csr_write;

   ssi_entry_type          push_entry, pop_entry;
   logic                   q_push, q_full, q_valid, q_pop;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_factor      <= signed'(SCALE_FACTOR_RESET);
         cfg_ff.inverse_time_step <= INVERSE_TIME_STEP_RESET;
         count_ff                 <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCALE_FACTOR:      cfg_ff.scale_factor      <= signed'(csr_data);
            CSR_INVERSE_TIME_STEP: cfg_ff.inverse_time_step <= csr_data;
            CSR_SAMPLE_COUNT:      count_ff                 <= csr_data[COUNT_WIDTH-1:0];
            default:               count_ff                 <= count_ff;
         endcase
      end
   end

   assign count_eff = (32'(count_ff) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(count_ff);

   ssi_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_sample_index (req_sample_index),
      .req_sample_value (req_sample_value),
      .req_query_time   (req_query_time),
      .count_zero       (count_eff == '0),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   ssi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry),
      .pop        (q_pop)
   );

   ssi_back #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .FRACTION_BITS (FRACTION_BITS),
      .CNT_W         (CNT_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (pop_entry),
      .q_pop            (q_pop),
      .cfg              (cfg_ff),
      .count_eff        (count_eff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_factor_value (rsp_factor_value),
      .rsp_peak_value   (rsp_peak_value),
      .rsp_in_range     (rsp_in_range)
   );

endmodule
